FILE: rtl/assert_macros.svh
// Assertion macros for the circle rasterizer RTL.
// Needs signals named clock and reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset
`define MCR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked while out of reset
`define MCR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/mcr_pkg.sv
// Shared types and constants for the midpoint circle rasterizer.
// No dependencies.
package mcr_pkg;

   localparam int SCREEN_W_DEF   = 1024;
   localparam int SCREEN_H_DEF   = 768;
   localparam int MAX_RADIUS_DEF = 1023;

   localparam logic [23:0] DRAW_COLOR_RST = 24'hFF0000;

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [9:0]         cx;
      logic [9:0]         cy;
      logic signed [11:0] x;
      logic signed [11:0] y;
      logic               done;
   } job_type;

endpackage

FILE: rtl/mcr_front.sv
// Front end: accepts start/step items, runs the midpoint error update.
// Pushes one octant job per emitting item into the queue. Uses mcr_pkg.
module mcr_front import mcr_pkg::*; #(
   parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_opcode,
   input  logic [9:0]   req_center_x,
   input  logic [9:0]   req_center_y,
   input  logic [9:0]   req_radius,
   input  logic         q_full,
   output logic         push,
   output job_type      push_job
);

   localparam logic [11:0] MaxRad = 12'(MAX_RADIUS);

   logic signed [11:0] cur_x_ff, cur_x_in;
   logic signed [11:0] cur_y_ff, cur_y_in;
   logic signed [12:0] err_ff, err_in;
   logic [9:0]         ccol_ff, ccol_in;
   logic [9:0]         crow_ff, crow_in;
   logic               active_ff, active_in;

   logic               accept;
   logic [11:0]        rad;
   logic signed [15:0] x16, y16, e1, e2;
   logic [15:0]        a1, a2;
   logic               diag;
   logic signed [11:0] nx, ny;
   logic               done;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_comb begin
      rad = {2'b00, req_radius};
      if (rad > MaxRad) begin
         rad = MaxRad;
      end
      x16  = {{4{cur_x_ff[11]}}, cur_x_ff};
      y16  = {{4{cur_y_ff[11]}}, cur_y_ff};
      e1   = {{3{err_ff[12]}}, err_ff} + (y16 <<< 1) + 16'sd1;
      e2   = e1 - (x16 <<< 1) + 16'sd1;
      a1   = e1[15] ? 16'(-e1) : 16'(e1);
      a2   = e2[15] ? 16'(-e2) : 16'(e2);
      diag = !(a1 < a2);
      nx   = diag ? cur_x_ff - 12'sd1 : cur_x_ff;
      ny   = cur_y_ff + 12'sd1;
      done = nx < ny;
   end

   always_comb begin
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      err_in    = err_ff;
      ccol_in   = ccol_ff;
      crow_in   = crow_ff;
      active_in = active_ff;
      push      = 1'b0;
      push_job  = '{cx: ccol_ff, cy: crow_ff, x: nx, y: ny, done: done};
      if (accept) begin
         if (req_opcode == OP_START) begin
            cur_x_in  = $signed(rad);
            cur_y_in  = '0;
            err_in    = '0;
            ccol_in   = req_center_x;
            crow_in   = req_center_y;
            active_in = 1'b1;
            push      = 1'b1;
            push_job  = '{cx: req_center_x, cy: req_center_y, x: $signed(rad),
                          y: 12'sd0, done: 1'b0};
         end else if (active_ff) begin
            cur_x_in  = nx;
            cur_y_in  = ny;
            err_in    = diag ? e2[12:0] : e1[12:0];
            active_in = !done;
            push      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff  <= '0;
         cur_y_ff  <= '0;
         err_ff    <= '0;
         ccol_ff   <= '0;
         crow_ff   <= '0;
         active_ff <= 1'b0;
      end else begin
         cur_x_ff  <= cur_x_in;
         cur_y_ff  <= cur_y_in;
         err_ff    <= err_in;
         ccol_ff   <= ccol_in;
         crow_ff   <= crow_in;
         active_ff <= active_in;
      end
   end

endmodule

FILE: rtl/mcr_queue.sv
// Short job queue between front end and pixel back end.
// Uses job_type and depth constants from mcr_pkg.
module mcr_queue import mcr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  job_type           push_job,
   input  logic              pop,
   output job_type           head,
   output logic              not_empty,
   output logic              full,
   output logic [QCNT_W-1:0] count
);

   job_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   localparam logic [QCNT_W-1:0] Depth = QCNT_W'(QUEUE_DEPTH);
   localparam logic [QPTR_W-1:0] LastPtr = QPTR_W'(QUEUE_DEPTH - 1);

   assign head      = mem_ff[rd_ptr_ff];
   assign not_empty = count_ff != '0;
   assign full      = count_ff == Depth;
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/mcr_back.sv
// Back end: walks the eight symmetric octants of the queued job,
// one pixel per cycle into the output register unless rsp_stall holds it. Uses mcr_pkg.
module mcr_back import mcr_pkg::*; #(
   parameter int SCREEN_W = SCREEN_W_DEF,
   parameter int SCREEN_H = SCREEN_H_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  job_type      job,
   input  logic         job_valid,
   output logic         pop,
   input  logic [23:0]  draw_color,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [11:0]  rsp_pixel_x,
   output logic [11:0]  rsp_pixel_y,
   output logic [23:0]  rsp_pixel_color,
   output logic         rsp_on_screen,
   output logic         rsp_last_of_step,
   output logic         rsp_circle_done
);

   localparam logic signed [13:0] ScrW = 14'(SCREEN_W);
   localparam logic signed [13:0] ScrH = 14'(SCREEN_H);

   logic [2:0]         k_ff, k_in;
   logic               valid_ff, valid_in;
   logic [11:0]        px_ff, py_ff;
   logic [23:0]        color_ff;
   logic               on_ff, last_ff, done_ff;

   logic               load;
   logic signed [13:0] xs, ys, cxs, cys, dx, dy, px, py;
   logic               on;

   assign load = job_valid && (!valid_ff || !rsp_stall);
   assign pop  = load && (k_ff == 3'd7);

   always_comb begin
      xs  = {{2{job.x[11]}}, job.x};
      ys  = {{2{job.y[11]}}, job.y};
      cxs = {4'b0000, job.cx};
      cys = {4'b0000, job.cy};
      case (k_ff)
         3'd0:    begin dx =  xs; dy =  ys; end
         3'd1:    begin dx =  ys; dy =  xs; end
         3'd2:    begin dx = -ys; dy =  xs; end
         3'd3:    begin dx = -xs; dy =  ys; end
         3'd4:    begin dx = -xs; dy = -ys; end
         3'd5:    begin dx = -ys; dy = -xs; end
         3'd6:    begin dx =  ys; dy = -xs; end
         default: begin dx =  xs; dy = -ys; end
      endcase
      px = cxs + dx;
      py = cys + dy;
      on = !px[13] && (px < ScrW) && !py[13] && (py < ScrH);
   end

   always_comb begin
      k_in     = k_ff;
      valid_in = valid_ff;
      if (load) begin
         k_in     = k_ff + 3'd1;
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff     <= '0;
         valid_ff <= 1'b0;
      end else begin
         k_ff     <= k_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         px_ff    <= px[11:0];
         py_ff    <= py[11:0];
         color_ff <= draw_color;
         on_ff    <= on;
         last_ff  <= k_ff == 3'd7;
         done_ff  <= job.done;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_pixel_x      = px_ff;
   assign rsp_pixel_y      = py_ff;
   assign rsp_pixel_color  = color_ff;
   assign rsp_on_screen    = on_ff;
   assign rsp_last_of_step = last_ff;
   assign rsp_circle_done  = done_ff;

endmodule

FILE: rtl/midpoint_circle_rasterizer.sv
// Midpoint circle rasterizer, eight-way symmetric. An accepted item is queued,
// then its pixels pass through the output register, one pixel per cycle while
// rsp_stall is low, eight per emitting item via the single pixel output port;
// the front end runs one item per cycle into a two-entry queue while not full.
// Sync active-high reset clears circle state, queue, output; draw color 0xFF0000.
`include "assert_macros.svh"
module midpoint_circle_rasterizer import mcr_pkg::*; #(
   parameter int SCREEN_W   = SCREEN_W_DEF,
   parameter int SCREEN_H   = SCREEN_H_DEF,
   parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [23:0]  csr_draw_color,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_opcode,
   input  logic [9:0]   req_center_x,
   input  logic [9:0]   req_center_y,
   input  logic [9:0]   req_radius,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [11:0]  rsp_pixel_x,
   output logic [11:0]  rsp_pixel_y,
   output logic [23:0]  rsp_pixel_color,
   output logic         rsp_on_screen,
   output logic         rsp_last_of_step,
   output logic         rsp_circle_done
);

   logic [23:0]       color_ff;
   logic              q_full, q_not_empty, push, pop;
   logic [QCNT_W-1:0] q_count;
   job_type           push_job, head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= DRAW_COLOR_RST;
      end else if (csr_valid && csr_ready) begin
         color_ff <= csr_draw_color;
      end
   end

   mcr_front #(.MAX_RADIUS(MAX_RADIUS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_opcode   (req_opcode),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_radius   (req_radius),
      .q_full       (q_full),
      .push         (push),
      .push_job     (push_job)
   );

   mcr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .head      (head),
      .not_empty (q_not_empty),
      .full      (q_full),
      .count     (q_count)
   );

   mcr_back #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)) u_back (
      .clock            (clock),
      .reset            (reset),
      .job              (head),
      .job_valid        (q_not_empty),
      .pop              (pop),
      .draw_color       (color_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_color  (rsp_pixel_color),
      .rsp_on_screen    (rsp_on_screen),
      .rsp_last_of_step (rsp_last_of_step),
      .rsp_circle_done  (rsp_circle_done)
   );

   `MCR_ASSERT_NEXT(a_start_queued, req_valid && !req_stall && req_opcode == OP_START, q_count != '0, "start item not queued")
   `MCR_ASSERT_NOW(a_pop_nonempty, pop, q_not_empty && !push_job.done || q_not_empty, "pop from empty queue")
   `MCR_ASSERT_NOW(a_push_room, push, !q_full || pop, "push into full queue")

endmodule
